@@ rtl/dfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dfp_pkg
// Shared types and constants for the decimal literal parser: character
// codes, parser phases, status codes and the result item layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfp_pkg;

  // Default limits on mantissa and exponent digit counts
  localparam int MAX_MANT_DIGITS_DEF = 30;
  localparam int MAX_EXP_DIGITS_DEF  = 5;

  // ASCII codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_E_LO  = 8'h65;

  // Parser phases
  localparam logic [1:0] PH_SIGN  = 2'd0;
  localparam logic [1:0] PH_MANT  = 2'd1;
  localparam logic [1:0] PH_ESIGN = 2'd2;
  localparam logic [1:0] PH_EXP   = 2'd3;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SIGN      = 4'd1;
  localparam logic [3:0] ST_NO_ESIGN  = 4'd2;
  localparam logic [3:0] ST_BAD_CHAR  = 4'd3;
  localparam logic [3:0] ST_E_COUNT   = 4'd4;
  localparam logic [3:0] ST_LONG_MANT = 4'd5;
  localparam logic [3:0] ST_LONG_EXP  = 4'd6;
  localparam logic [3:0] ST_NO_MANT   = 4'd7;
  localparam logic [3:0] ST_NO_EXP    = 4'd8;
  localparam logic [3:0] ST_DOTS      = 4'd9;

  // Result kinds
  localparam logic KIND_DIGIT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Saturation points
  localparam logic [4:0]  MANT_SAT = 5'd31;
  localparam logic [2:0]  EXPC_SAT = 3'd7;
  localparam logic [1:0]  DOTS_SAT = 2'd3;
  localparam logic [1:0]  ECNT_SAT = 2'd3;
  localparam logic [16:0] EXP_SAT  = 17'd99999;

  // Queue depth for result items
  localparam int OUTQ_DEPTH = 4;

  // One result item
  typedef struct packed {
    logic               kind;
    logic [3:0]         digit_value;
    logic [3:0]         status;
    logic               negative;
    logic [4:0]         mantissa_digits;
    logic               has_dot;
    logic [4:0]         digits_before_dot;
    logic signed [17:0] exponent_value;
    logic               last_of_run;
  } res_t;

  // Results produced by one step, handed to the queue
  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

@@ rtl/dfp_step.sv @@
// ----------------------------------------------------------------------------
// dfp_step
// Parser state and the per-character step: validates one character, updates
// counters and the exponent accumulator, and forms up to two result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfp_step #(
  parameter int MAX_MANT_DIGITS = dfp_pkg::MAX_MANT_DIGITS_DEF,
  parameter int MAX_EXP_DIGITS  = dfp_pkg::MAX_EXP_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  logic [7:0]    char_code,
  input  logic          end_of_text,
  output dfp_pkg::push_t push
);

  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  err_r, err_nxt;
  logic        sign_neg_r, sign_neg_nxt;
  logic [4:0]  mant_cnt_r, mant_cnt_nxt;
  logic [2:0]  exp_cnt_r, exp_cnt_nxt;
  logic [1:0]  e_cnt_r, e_cnt_nxt;
  logic [1:0]  dot_cnt_r, dot_cnt_nxt;
  logic [4:0]  dot_pos_r, dot_pos_nxt;
  logic [16:0] exp_acc_r, exp_acc_nxt;
  logic        exp_neg_r, exp_neg_nxt;

  logic        is_digit, is_sign, is_e, emit_digit;
  logic [3:0]  digit;
  logic [20:0] acc_ext, exp_sum;
  logic [3:0]  status;
  logic [17:0] exp_mag;
  dfp_pkg::res_t dig_res, sum_res;

  // Character classes
  assign is_digit = (char_code >= dfp_pkg::CH_ZERO) && (char_code <= dfp_pkg::CH_NINE);
  assign is_sign  = (char_code == dfp_pkg::CH_PLUS) || (char_code == dfp_pkg::CH_MINUS);
  assign is_e     = (char_code == dfp_pkg::CH_E_LO) || (char_code == dfp_pkg::CH_E_UP);
  assign digit    = 4'(char_code - dfp_pkg::CH_ZERO);

  // acc*10 + digit as shift-and-add
  assign acc_ext = {4'b0, exp_acc_r};
  assign exp_sum = (acc_ext << 3) + (acc_ext << 1) + {17'b0, digit};

  // Next state for one character
  always_comb begin
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    sign_neg_nxt = sign_neg_r;
    mant_cnt_nxt = mant_cnt_r;
    exp_cnt_nxt  = exp_cnt_r;
    e_cnt_nxt    = e_cnt_r;
    dot_cnt_nxt  = dot_cnt_r;
    dot_pos_nxt  = dot_pos_r;
    exp_acc_nxt  = exp_acc_r;
    exp_neg_nxt  = exp_neg_r;
    emit_digit   = 1'b0;
    if (err_r == dfp_pkg::ST_OK) begin
      case (phase_r)
        dfp_pkg::PH_SIGN: begin
          if (is_sign) begin
            sign_neg_nxt = (char_code == dfp_pkg::CH_MINUS);
            phase_nxt    = dfp_pkg::PH_MANT;
          end else begin
            err_nxt = dfp_pkg::ST_SIGN;
          end
        end
        dfp_pkg::PH_MANT: begin
          if (is_digit) begin
            if (mant_cnt_r != dfp_pkg::MANT_SAT) mant_cnt_nxt = mant_cnt_r + 5'd1;
            emit_digit = 1'b1;
          end else if (char_code == dfp_pkg::CH_DOT) begin
            if (dot_cnt_r == 2'd0) dot_pos_nxt = mant_cnt_r;
            if (dot_cnt_r != dfp_pkg::DOTS_SAT) dot_cnt_nxt = dot_cnt_r + 2'd1;
          end else if (is_e) begin
            if (e_cnt_r != dfp_pkg::ECNT_SAT) e_cnt_nxt = e_cnt_r + 2'd1;
            phase_nxt = dfp_pkg::PH_ESIGN;
          end else begin
            err_nxt = dfp_pkg::ST_BAD_CHAR;
          end
        end
        dfp_pkg::PH_ESIGN: begin
          if (is_sign) begin
            exp_neg_nxt = (char_code == dfp_pkg::CH_MINUS);
            phase_nxt   = dfp_pkg::PH_EXP;
          end else begin
            err_nxt = dfp_pkg::ST_NO_ESIGN;
          end
        end
        default: begin
          if (is_digit) begin
            if (exp_cnt_r != dfp_pkg::EXPC_SAT) exp_cnt_nxt = exp_cnt_r + 3'd1;
            exp_acc_nxt = (exp_sum > {4'b0, dfp_pkg::EXP_SAT}) ? dfp_pkg::EXP_SAT
                                                              : exp_sum[16:0];
          end else if (is_e) begin
            if (e_cnt_r != dfp_pkg::ECNT_SAT) e_cnt_nxt = e_cnt_r + 2'd1;
            phase_nxt = dfp_pkg::PH_ESIGN;
          end else begin
            err_nxt = dfp_pkg::ST_BAD_CHAR;
          end
        end
      endcase
    end
  end

  // Final status, judged on the state after this character
  always_comb begin
    if (err_nxt != dfp_pkg::ST_OK)                     status = err_nxt;
    else if (phase_nxt == dfp_pkg::PH_ESIGN)           status = dfp_pkg::ST_NO_ESIGN;
    else if (e_cnt_nxt != 2'd1)                        status = dfp_pkg::ST_E_COUNT;
    else if (mant_cnt_nxt > 5'(MAX_MANT_DIGITS))       status = dfp_pkg::ST_LONG_MANT;
    else if (exp_cnt_nxt > 3'(MAX_EXP_DIGITS))         status = dfp_pkg::ST_LONG_EXP;
    else if (mant_cnt_nxt == 5'd0)                     status = dfp_pkg::ST_NO_MANT;
    else if (exp_cnt_nxt == 3'd0)                      status = dfp_pkg::ST_NO_EXP;
    else if (dot_cnt_nxt > 2'd1)                       status = dfp_pkg::ST_DOTS;
    else                                               status = dfp_pkg::ST_OK;
  end

  assign exp_mag = {1'b0, exp_acc_nxt};

  // Result items
  always_comb begin
    dig_res             = '0;
    dig_res.kind        = dfp_pkg::KIND_DIGIT;
    dig_res.digit_value = digit;
    dig_res.last_of_run = ~end_of_text;

    sum_res             = '0;
    sum_res.kind        = dfp_pkg::KIND_SUMMARY;
    sum_res.status      = status;
    sum_res.last_of_run = 1'b1;
    if (status == dfp_pkg::ST_OK) begin
      sum_res.negative          = sign_neg_nxt;
      sum_res.mantissa_digits   = mant_cnt_nxt;
      sum_res.has_dot           = (dot_cnt_nxt != 2'd0);
      sum_res.digits_before_dot = (dot_cnt_nxt != 2'd0) ? dot_pos_nxt : 5'd0;
      sum_res.exponent_value    = exp_neg_nxt ? -exp_mag : exp_mag;
    end
  end

  // Hand results to the queue
  always_comb begin
    push        = '0;
    push.first  = emit_digit ? dig_res : sum_res;
    push.second = sum_res;
    if (go) begin
      push.n = {1'b0, emit_digit} + {1'b0, end_of_text};
    end
  end

  // State registers; the closing character returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (go && end_of_text)) begin
      phase_r    <= dfp_pkg::PH_SIGN;
      err_r      <= dfp_pkg::ST_OK;
      sign_neg_r <= 1'b0;
      mant_cnt_r <= '0;
      exp_cnt_r  <= '0;
      e_cnt_r    <= '0;
      dot_cnt_r  <= '0;
      dot_pos_r  <= '0;
      exp_acc_r  <= '0;
      exp_neg_r  <= 1'b0;
    end else if (go) begin
      phase_r    <= phase_nxt;
      err_r      <= err_nxt;
      sign_neg_r <= sign_neg_nxt;
      mant_cnt_r <= mant_cnt_nxt;
      exp_cnt_r  <= exp_cnt_nxt;
      e_cnt_r    <= e_cnt_nxt;
      dot_cnt_r  <= dot_cnt_nxt;
      dot_pos_r  <= dot_pos_nxt;
      exp_acc_r  <= exp_acc_nxt;
      exp_neg_r  <= exp_neg_nxt;
    end
  end

endmodule

@@ rtl/dfp_outq.sv @@
// ----------------------------------------------------------------------------
// dfp_outq
// Small result queue: takes up to two items per cycle from the step logic
// and presents one item per cycle on the output channel while not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfp_outq (
  input  logic           clk,
  input  logic           rst_n,
  input  dfp_pkg::push_t push,
  input  logic           pop,
  output logic           room,
  output logic           not_empty,
  output dfp_pkg::res_t  head
);

  localparam int PW = $clog2(dfp_pkg::OUTQ_DEPTH);

  dfp_pkg::res_t q_r [dfp_pkg::OUTQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic [PW-1:0] wr_ptr_2;

  assign not_empty = (count_r != '0);
  // Room for two more items regardless of this cycle's pop
  assign room      = (count_r <= (PW+1)'(dfp_pkg::OUTQ_DEPTH - 2));
  assign head      = q_r[rd_ptr_r];
  assign wr_ptr_2  = wr_ptr_r + PW'(1);

  // Pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + (PW+1)'(push.n) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wr_ptr_r] <= push.first;
    if (push.n == 2'd2) q_r[wr_ptr_2] <= push.second;
  end

endmodule

@@ rtl/decimal_float_literal_parser.sv @@
// ----------------------------------------------------------------------------
// decimal_float_literal_parser
// Streaming validator for signed scientific-notation literals.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while in_stall is low and checks it
// against the form sign, mantissa digits with an optional point, e or E, sign,
// exponent digits. Each mantissa digit goes out as a digit item while no error
// has been seen; the character flagged end_of_text closes the literal with a
// summary item and returns the parser to its start. A character passes through
// an input register, the parse step, and a four-entry result queue: the results
// it causes enter the queue when the step takes it from the input register, and
// the queue head is presented on the output. A mantissa digit that is also the
// closing character produces two items, a digit item and a summary item; a
// character waits in the input register, and input is held off, whenever the
// queue holds more than two items, so with the output side draining every cycle
// the block sustains one character per cycle.
`timescale 1ns / 1ps

module decimal_float_literal_parser #(
  parameter int MAX_MANT_DIGITS = dfp_pkg::MAX_MANT_DIGITS_DEF,
  parameter int MAX_EXP_DIGITS  = dfp_pkg::MAX_EXP_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_code,
  input  logic               in_end_of_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [3:0]         out_digit_value,
  output logic [3:0]         out_status,
  output logic               out_negative,
  output logic [4:0]         out_mantissa_digits,
  output logic               out_has_dot,
  output logic [4:0]         out_digits_before_dot,
  output logic signed [17:0] out_exponent_value,
  output logic               out_last_of_run
);

  logic          stage_v_r, stage_v_nxt;
  logic [7:0]    char_r;
  logic          eot_r;
  logic          accept, go, room, pop;
  dfp_pkg::push_t push;
  dfp_pkg::res_t  head;

  // Input register
  assign go       = stage_v_r && room;
  assign in_stall = stage_v_r && !room;
  assign accept   = in_valid && !in_stall;
  assign stage_v_nxt = accept || (stage_v_r && !go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_r <= in_char_code;
      eot_r  <= in_end_of_text;
    end
  end

  // Parse step
  dfp_step #(
    .MAX_MANT_DIGITS (MAX_MANT_DIGITS),
    .MAX_EXP_DIGITS  (MAX_EXP_DIGITS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .go          (go),
    .char_code   (char_r),
    .end_of_text (eot_r),
    .push        (push)
  );

  // Result queue
  assign pop = out_valid && !out_stall;

  dfp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_kind              = head.kind;
  assign out_digit_value       = head.digit_value;
  assign out_status            = head.status;
  assign out_negative          = head.negative;
  assign out_mantissa_digits   = head.mantissa_digits;
  assign out_has_dot           = head.has_dot;
  assign out_digits_before_dot = head.digits_before_dot;
  assign out_exponent_value    = head.exponent_value;
  assign out_last_of_run       = head.last_of_run;

  // A summary always closes its item's run
  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == dfp_pkg::KIND_SUMMARY) |-> out_last_of_run)
    else $error("summary item without last_of_run");

  // Digit items carry a decimal digit and no status
  a_digit_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == dfp_pkg::KIND_DIGIT) |->
      (out_digit_value <= 4'd9) && (out_status == dfp_pkg::ST_OK))
    else $error("malformed digit item");

  // A failed literal reports no numeric fields
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == dfp_pkg::KIND_SUMMARY) && (out_status != dfp_pkg::ST_OK) |->
      (out_mantissa_digits == 5'd0) && !out_has_dot && (out_exponent_value == 18'sd0))
    else $error("error summary carries numeric fields");

  // A held character stays in the input register until the step takes it
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stage_v_r && !go |=> stage_v_r && $stable(char_r) && $stable(eot_r))
    else $error("input register lost a pending character");

endmodule

@@ test/tb_decimal_float_literal_parser.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_float_literal_parser
// Checks the literal parser against a cycle-free model of its parse rules.
// A driver presents characters from a queue of whole literals, and each
// accepted character updates the testbench's own parser state. That update
// queues the digit and summary items the character should cause. A monitor
// checks every result item, field by field, against the oldest queued
// expectation. Both sides idle and stall at random, except over one stretch
// in the middle of the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_decimal_float_literal_parser;

  typedef struct {
    logic [7:0] code;
    logic       last;
    bit         hold;   // wait for all results before presenting
  } char_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_code = '0;
  logic               in_end_of_text = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_kind;
  logic [3:0]         out_digit_value;
  logic [3:0]         out_status;
  logic               out_negative;
  logic [4:0]         out_mantissa_digits;
  logic               out_has_dot;
  logic [4:0]         out_digits_before_dot;
  logic signed [17:0] out_exponent_value;
  logic               out_last_of_run;

  char_item_t    pending_q[$];
  dfp_pkg::res_t expected_q[$];
  int            sent_cnt = 0;
  int            fails = 0;

  // Parser state tracked by the testbench
  logic [1:0]  p_phase;
  logic [3:0]  p_err;
  logic        p_neg;
  logic [4:0]  p_mant_cnt;
  logic [2:0]  p_exp_cnt;
  logic [1:0]  p_e_cnt;
  logic [1:0]  p_dot_cnt;
  logic [4:0]  p_dot_pos;
  logic [16:0] p_exp_acc;
  logic        p_exp_neg;

  decimal_float_literal_parser dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_char_code         (in_char_code),
    .in_end_of_text       (in_end_of_text),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_digit_value      (out_digit_value),
    .out_status           (out_status),
    .out_negative         (out_negative),
    .out_mantissa_digits  (out_mantissa_digits),
    .out_has_dot          (out_has_dot),
    .out_digits_before_dot(out_digits_before_dot),
    .out_exponent_value   (out_exponent_value),
    .out_last_of_run      (out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_parser();
    p_phase   = dfp_pkg::PH_SIGN;
    p_err     = dfp_pkg::ST_OK;
    p_neg     = 1'b0;
    p_mant_cnt = '0;
    p_exp_cnt = '0;
    p_e_cnt   = '0;
    p_dot_cnt = '0;
    p_dot_pos = '0;
    p_exp_acc = '0;
    p_exp_neg = 1'b0;
  endtask

  // Advance the parser by one character and queue the items it causes
  task automatic parse_char(input logic [7:0] c, input logic eot);
    dfp_pkg::res_t r;
    logic [3:0]    st;
    logic [17:0]   ev;
    int unsigned   acc;
    logic          is_dig;
    logic          is_e;
    logic          is_sgn;
    is_dig = (c >= dfp_pkg::CH_ZERO) && (c <= dfp_pkg::CH_NINE);
    is_e   = (c == dfp_pkg::CH_E_UP) || (c == dfp_pkg::CH_E_LO);
    is_sgn = (c == dfp_pkg::CH_PLUS) || (c == dfp_pkg::CH_MINUS);
    if (p_err == dfp_pkg::ST_OK) begin
      case (p_phase)
        dfp_pkg::PH_SIGN: begin
          if (is_sgn) begin
            p_neg   = (c == dfp_pkg::CH_MINUS);
            p_phase = dfp_pkg::PH_MANT;
          end else begin
            p_err = dfp_pkg::ST_SIGN;
          end
        end
        dfp_pkg::PH_MANT: begin
          if (is_dig) begin
            if (p_mant_cnt != dfp_pkg::MANT_SAT) p_mant_cnt++;
            r = '0;
            r.kind        = dfp_pkg::KIND_DIGIT;
            r.digit_value = 4'(c - dfp_pkg::CH_ZERO);
            r.last_of_run = !eot;
            expected_q.push_back(r);
          end else if (c == dfp_pkg::CH_DOT) begin
            if (p_dot_cnt == 0) p_dot_pos = p_mant_cnt;
            if (p_dot_cnt != dfp_pkg::DOTS_SAT) p_dot_cnt++;
          end else if (is_e) begin
            if (p_e_cnt != dfp_pkg::ECNT_SAT) p_e_cnt++;
            p_phase = dfp_pkg::PH_ESIGN;
          end else begin
            p_err = dfp_pkg::ST_BAD_CHAR;
          end
        end
        dfp_pkg::PH_ESIGN: begin
          if (is_sgn) begin
            p_exp_neg = (c == dfp_pkg::CH_MINUS);
            p_phase   = dfp_pkg::PH_EXP;
          end else begin
            p_err = dfp_pkg::ST_NO_ESIGN;
          end
        end
        default: begin
          if (is_dig) begin
            acc = p_exp_acc * 10 + (c - dfp_pkg::CH_ZERO);
            if (p_exp_cnt != dfp_pkg::EXPC_SAT) p_exp_cnt++;
            p_exp_acc = (acc > dfp_pkg::EXP_SAT) ? dfp_pkg::EXP_SAT : 17'(acc);
          end else if (is_e) begin
            if (p_e_cnt != dfp_pkg::ECNT_SAT) p_e_cnt++;
            p_phase = dfp_pkg::PH_ESIGN;
          end else begin
            p_err = dfp_pkg::ST_BAD_CHAR;
          end
        end
      endcase
    end

    // Closing character: summary in priority order, then back to start
    if (eot) begin
      if (p_err != dfp_pkg::ST_OK)                        st = p_err;
      else if (p_phase == dfp_pkg::PH_ESIGN)              st = dfp_pkg::ST_NO_ESIGN;
      else if (p_e_cnt != 2'd1)                           st = dfp_pkg::ST_E_COUNT;
      else if (p_mant_cnt > dfp_pkg::MAX_MANT_DIGITS_DEF) st = dfp_pkg::ST_LONG_MANT;
      else if (p_exp_cnt > dfp_pkg::MAX_EXP_DIGITS_DEF)   st = dfp_pkg::ST_LONG_EXP;
      else if (p_mant_cnt == 0)                           st = dfp_pkg::ST_NO_MANT;
      else if (p_exp_cnt == 0)                            st = dfp_pkg::ST_NO_EXP;
      else if (p_dot_cnt > 2'd1)                          st = dfp_pkg::ST_DOTS;
      else                                                st = dfp_pkg::ST_OK;
      r = '0;
      r.kind        = dfp_pkg::KIND_SUMMARY;
      r.status      = st;
      r.last_of_run = 1'b1;
      if (st == dfp_pkg::ST_OK) begin
        ev = {1'b0, p_exp_acc};
        if (p_exp_neg) ev = -ev;
        r.negative          = p_neg;
        r.mantissa_digits   = p_mant_cnt;
        r.has_dot           = (p_dot_cnt != 0);
        r.digits_before_dot = (p_dot_cnt != 0) ? p_dot_pos : 5'd0;
        r.exponent_value    = ev;
      end
      expected_q.push_back(r);
      clear_parser();
    end
  endtask

  task automatic check_field(input string fname, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fails++;
    end
  endtask

  // Idle-free stretch in the middle of the run
  function automatic bit quiet_window();
    return sent_cnt >= 250 && sent_cnt < 400;
  endfunction

  task automatic add_char(input logic [7:0] c, input logic eot, input bit hold);
    char_item_t it;
    it.code = c;
    it.last = eot;
    it.hold = hold;
    pending_q.push_back(it);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1, 1'b0);
  endtask

  // One random literal: mostly well formed, some broken, some noise
  task automatic add_literal(input bit hold_first);
    logic [7:0] txt[$];
    int         n_mant;
    int         n_dot;
    int         n_e;
    int         n_exp;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(255)));
    end else begin
      txt.push_back($urandom_range(1) ? dfp_pkg::CH_MINUS : dfp_pkg::CH_PLUS);
      n_mant = ($urandom_range(9) == 0) ? $urandom_range(28, 33) : $urandom_range(0, 8);
      repeat (n_mant) txt.push_back(8'(dfp_pkg::CH_ZERO + $urandom_range(9)));
      pick = $urandom_range(9);
      n_dot = (pick < 4) ? 0 : (pick < 9) ? 1 : $urandom_range(2, 4);
      repeat (n_dot) txt.insert($urandom_range(1, txt.size()), dfp_pkg::CH_DOT);
      n_e = ($urandom_range(9) == 0) ? $urandom_range(0, 4) : 1;
      repeat (n_e) begin
        txt.push_back($urandom_range(1) ? dfp_pkg::CH_E_UP : dfp_pkg::CH_E_LO);
        txt.push_back($urandom_range(1) ? dfp_pkg::CH_MINUS : dfp_pkg::CH_PLUS);
        n_exp = ($urandom_range(9) == 0) ? $urandom_range(0, 9) : $urandom_range(1, 5);
        repeat (n_exp)
          txt.push_back(($urandom_range(3) == 0) ? dfp_pkg::CH_NINE
                                                 : 8'(dfp_pkg::CH_ZERO + $urandom_range(9)));
      end
      // break some of them: a wrong character or a cut-short literal
      pick = $urandom_range(99);
      if (pick < 10)
        txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
      else if (pick < 16 && txt.size() > 1)
        repeat ($urandom_range(1, txt.size() - 1)) void'(txt.pop_back());
    end
    foreach (txt[i]) add_char(txt[i], i == txt.size() - 1, hold_first && i == 0);
  endtask

  // Driver: presents the next character once the current one is taken
  always @(posedge clk) begin : drive_p
    char_item_t nxt;
    bit         ready;
    if (!rst_n) begin
      in_valid       <= 1'b0;
      in_char_code   <= '0;
      in_end_of_text <= 1'b0;
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        parse_char(in_char_code, in_end_of_text);
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        ready = pending_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 30);
        if (ready && pending_q[0].hold && expected_q.size() != 0) ready = 1'b0;
        if (ready) begin
          nxt = pending_q.pop_front();
          in_valid       <= 1'b1;
          in_char_code   <= nxt.code;
          in_end_of_text <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item, then picks the next stall
  always @(posedge clk) begin : watch_p
    dfp_pkg::res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result item with none expected");
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", want.kind, out_kind);
          check_field("digit_value", want.digit_value, out_digit_value);
          check_field("status", want.status, out_status);
          check_field("negative", want.negative, out_negative);
          check_field("mantissa_digits", want.mantissa_digits, out_mantissa_digits);
          check_field("has_dot", want.has_dot, out_has_dot);
          check_field("digits_before_dot", want.digits_before_dot, out_digits_before_dot);
          check_field("exponent_value", want.exponent_value, out_exponent_value);
          check_field("last_of_run", want.last_of_run, out_last_of_run);
        end
      end
      out_stall <= !quiet_window() && ($urandom_range(99) < 30);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int lit_no;
    // directed: extremes, both e letters, errors in the sign, mantissa and exponent sign
    add_text("-0.9E-9");
    add_char(8'hFF, 1'b1, 1'b0);   // bad leading sign, all ones
    add_char(8'h00, 1'b1, 1'b0);   // bad leading sign, all zeros
    add_text("+1e");               // ends right after e
    add_text("+.e+7");             // empty mantissa
    add_text("+5e5");              // no sign after e
    lit_no = 0;
    while (pending_q.size() < 645) begin
      add_literal(lit_no % 60 == 0);
      lit_no++;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ decimal_float_literal_parser.f @@
rtl/dfp_pkg.sv
rtl/dfp_step.sv
rtl/dfp_outq.sv
rtl/decimal_float_literal_parser.sv
test/tb_decimal_float_literal_parser.sv
